/* rtl/hcdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcdt_pkg: shared types and constants of the holiday calendar day-type unit
// Table geometry, entry layout, request and register codes, and the month
// offset table of the weekday calculation.
// ----------------------------------------------------------------------------
`default_nettype none

package hcdt_pkg;

  // Holiday table geometry.
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Request operations.
  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_WRITE    = 1'b1;

  // Register select (bit 2 of the byte address).
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  // Day type codes.
  localparam logic [1:0] DT_WORKDAY  = 2'd0;
  localparam logic [1:0] DT_SATURDAY = 2'd1;
  localparam logic [1:0] DT_HOLIDAY  = 2'd2;

  // Weekday arithmetic: years count from 2000, mod 7 by reciprocal.
  localparam int BASE_YEAR   = 2000;
  localparam int RECIP_7     = 2341;
  localparam int RECIP_SHIFT = 14;

  // One holiday table entry.
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] month;
    logic [4:0] day;
  } entry_t;

  // Write request into the holiday table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  // Month offset of the Gregorian weekday rule, for months 1 to 12.
  function automatic logic [2:0] month_offset(input logic [3:0] m);
    logic [2:0] off;
    unique case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

/* rtl/hcdt_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcdt_table: holiday table memory
// One write port and one read port; the read data is registered, so an entry
// appears in the cycle after its address is presented.
// ----------------------------------------------------------------------------
`default_nettype none

module hcdt_table (
  input  wire logic                     clk,
  input  wire hcdt_pkg::tbl_wr_t        wr,
  input  wire logic [hcdt_pkg::IDX_W-1:0] raddr,
  output hcdt_pkg::entry_t              rdata
);

  hcdt_pkg::entry_t mem [hcdt_pkg::TABLE_ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/hcdt_weekday.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcdt_weekday: weekday day-type calculation
// Two register stages: the first forms the Gregorian day sum, the second
// reduces it modulo 7 and maps Saturday and Sunday to their day types.
// ----------------------------------------------------------------------------
`default_nettype none

module hcdt_weekday (
  input  wire logic       clk,
  input  wire logic [6:0] year_in_century,
  input  wire logic [3:0] month_number,
  input  wire logic [4:0] day_of_month,
  output logic      [1:0] week_type
);

  // Remainder codes, counted from Sunday.
  localparam logic [2:0] REM_SUNDAY   = 3'd0;
  localparam logic [2:0] REM_SATURDAY = 3'd6;

  logic [3:0]  m_eff;
  logic        early;
  logic [11:0] yr;
  logic [9:0]  q4;
  logic [4:0]  c100;
  logic [2:0]  c400;
  logic [11:0] sum_next;
  logic [11:0] sum;
  logic [23:0] prod;
  logic [11:0] quot;
  logic [11:0] rem;
  logic [1:0]  week_type_next;

  // Stage one: year, leap corrections, month offset and day.
  // Years run from 1999 to 2127, so the year needs twelve bits.
  always_comb begin
    m_eff = (month_number >= 4'd1 && month_number <= 4'd12) ? month_number : 4'd1;
    early = (m_eff < 4'd3);
    yr    = 12'(hcdt_pkg::BASE_YEAR) + 12'(year_in_century) - 12'(early);
    q4    = yr[11:2];
    if (yr >= 12'd2100) begin
      c100 = 5'd21;
    end else if (yr >= 12'd2000) begin
      c100 = 5'd20;
    end else begin
      c100 = 5'd19;
    end
    c400     = (yr >= 12'd2000) ? 3'd5 : 3'd4;
    sum_next = yr + 12'(q4) + 12'(c400) + 12'(hcdt_pkg::month_offset(m_eff))
             + 12'(day_of_month) - 12'(c100);
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

  // Stage two: modulo 7 through a reciprocal multiply, then the type.
  always_comb begin
    prod = 24'(sum) * 24'(hcdt_pkg::RECIP_7);
    quot = 12'(prod >> hcdt_pkg::RECIP_SHIFT);
    rem  = sum - quot * 12'd7;
    unique case (rem[2:0])
      REM_SUNDAY:   week_type_next = hcdt_pkg::DT_HOLIDAY;
      REM_SATURDAY: week_type_next = hcdt_pkg::DT_SATURDAY;
      default:      week_type_next = hcdt_pkg::DT_WORKDAY;
    endcase
  end

  always_ff @(posedge clk) begin
    week_type <= week_type_next;
  end

endmodule

`default_nettype wire

/* rtl/holiday_calendar_day_type_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// holiday_calendar_day_type_unit: tariff day-type classifier
// Stores holiday entries in a table and classifies dates as workday,
// Saturday type or Sunday/holiday type.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. operation selects
//   a table write (entry_index, day_of_month, month_number, entry_day_type)
//   or a date classification (year_in_century, month_number, day_of_month).
//   Every request gives one result: done is high for one cycle with day_type.
//   A write, or a classification with day_type_enable low, answers in the
//   cycle after the request and never raises busy.
//   A classification walks the table one entry a cycle through the table
//   memory's single read port and compares the entries below limit, where
//   limit is holiday_count clipped to 32. A match ends the scan with that
//   entry's type; with no match the weekday result follows after the last
//   entry, through ST_WEEK1 and ST_WEEK2. busy stays high until the result
//   is shown, and the next request can be taken in the cycle that shows it.
//   Reset clears both registers and the control state; table entries hold
//   anything until written. The receiver cannot stall: each result is shown
//   for one cycle only. The user writes the registers through the APB port
//   only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module holiday_calendar_day_type_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel.
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [6:0]  year_in_century,
  input  wire logic [3:0]  month_number,
  input  wire logic [4:0]  day_of_month,
  input  wire logic [4:0]  entry_index,
  input  wire logic [1:0]  entry_day_type,
  // Result channel.
  output logic             done,
  output logic [1:0]       day_type,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CNT_W = hcdt_pkg::CNT_W;
  localparam int IDX_W = hcdt_pkg::IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WEEK1 = 4'b0100,
    ST_WEEK2 = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic              day_type_enable;
  logic [5:0]        holiday_count;
  logic [6:0]        req_year;
  logic [3:0]        req_month;
  logic [4:0]        req_day;
  logic [CNT_W-1:0]  limit, limit_next;
  logic [CNT_W-1:0]  rd_cnt, rd_cnt_next;
  logic              rd_vld, rd_vld_next;
  logic              done_next;
  logic [1:0]        day_type_next;
  logic              accept;
  logic              cfg_wr;
  logic              match;
  logic [1:0]        week_type;
  hcdt_pkg::tbl_wr_t tbl_wr;
  hcdt_pkg::entry_t  rd_data;

  // Register port: always ready, writes on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      day_type_enable <= 1'b0;
      holiday_count   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        hcdt_pkg::REG_ENABLE: day_type_enable <= pwdata[0];
        hcdt_pkg::REG_COUNT:  holiday_count   <= pwdata[5:0];
        default:              day_type_enable <= day_type_enable;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      hcdt_pkg::REG_ENABLE: prdata = {31'd0, day_type_enable};
      hcdt_pkg::REG_COUNT:  prdata = {26'd0, holiday_count};
      default:              prdata = '0;
    endcase
  end

  // Request acceptance and table write.
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    tbl_wr.en   = accept && (operation == hcdt_pkg::OP_WRITE)
               && (32'(entry_index) < hcdt_pkg::TABLE_ENTRIES);
    tbl_wr.addr = IDX_W'(entry_index);
    tbl_wr.data = '{kind: entry_day_type, month: month_number, day: day_of_month};
  end

  // Number of entries searched, clipped to the table size.
  assign limit_next = (32'(holiday_count) > hcdt_pkg::TABLE_ENTRIES)
                    ? CNT_W'(hcdt_pkg::TABLE_ENTRIES) : CNT_W'(holiday_count);

  hcdt_table u_table (
    .clk   (clk),
    .wr    (tbl_wr),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  hcdt_weekday u_weekday (
    .clk             (clk),
    .year_in_century (req_year),
    .month_number    (req_month),
    .day_of_month    (req_day),
    .week_type       (week_type)
  );

  // The entry read last cycle is compared against the request date.
  assign match = rd_vld && (rd_data.day == req_day) && (rd_data.month == req_month);

  // Sequencer: scan the table, then fall back to the weekday.
  always_comb begin
    state_next    = state;
    rd_cnt_next   = rd_cnt;
    rd_vld_next   = 1'b0;
    done_next     = 1'b0;
    day_type_next = day_type;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == hcdt_pkg::OP_WRITE || !day_type_enable) begin
            done_next     = 1'b1;
            day_type_next = hcdt_pkg::DT_WORKDAY;
          end else begin
            state_next  = ST_SCAN;
            rd_cnt_next = '0;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_next    = ST_IDLE;
          done_next     = 1'b1;
          day_type_next = rd_data.kind;
        end else if (rd_cnt == limit) begin
          state_next = ST_WEEK1;
        end else begin
          rd_cnt_next = rd_cnt + CNT_W'(1);
          rd_vld_next = 1'b1;
        end
      end
      ST_WEEK1: begin
        state_next = ST_WEEK2;
      end
      ST_WEEK2: begin
        state_next    = ST_IDLE;
        done_next     = 1'b1;
        day_type_next = week_type;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_cnt <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_cnt <= rd_cnt_next;
      rd_vld <= rd_vld_next;
      done   <= done_next;
    end
  end

  // Request fields and result value.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_year  <= year_in_century;
      req_month <= month_number;
      req_day   <= day_of_month;
      limit     <= limit_next;
    end
    day_type <= day_type_next;
  end

  // A table write answers workday in the next cycle.
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == hcdt_pkg::OP_WRITE) |=> (done && day_type == hcdt_pkg::DT_WORKDAY))
    else $error("table write did not answer workday");

  // With the mode off a classification answers workday in the next cycle.
  a_disabled_result: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == hcdt_pkg::OP_CLASSIFY && !day_type_enable)
      |=> (done && day_type == hcdt_pkg::DT_WORKDAY))
    else $error("disabled classification did not answer workday");

  // The scan counter never runs past the number of entries in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_cnt <= limit))
    else $error("table scan ran past its limit");

  // The weekday step always ends in a result.
  a_week_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WEEK2) |=> (done && !busy))
    else $error("weekday step ended without a result");

endmodule

`default_nettype wire
